@@ hdl/rgb_rop_pkg.sv @@
package rgb_rop_pkg;

    localparam int AddrW = 16;
    localparam int StoreWords = 1 << AddrW;
    localparam int DimW = 11;
    localparam int MaxDim = 1024;
    localparam int CoordW = 18;

    localparam logic [2:0] ReqPixel = 3'd0;
    localparam logic [2:0] ReqGet = 3'd1;
    localparam logic [2:0] ReqSpan = 3'd2;
    localparam logic [2:0] ReqFill = 3'd3;
    localparam logic [2:0] ReqBlit = 3'd4;
    localparam logic [2:0] ReqRgb = 3'd5;

    localparam logic [3:0] RopXor = 4'd1;
    localparam logic [3:0] RopTransparent = 4'd7;

    localparam logic [2:0] RegDstBase = 3'd0;
    localparam logic [2:0] RegDstWidth = 3'd1;
    localparam logic [2:0] RegDstHeight = 3'd2;
    localparam logic [2:0] RegDstKey = 3'd3;
    localparam logic [2:0] RegSrcBase = 3'd4;
    localparam logic [2:0] RegSrcWidth = 3'd5;
    localparam logic [2:0] RegSrcHeight = 3'd6;
    localparam logic [2:0] RegSrcKey = 3'd7;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SETUP = 7'b0000010,
        ST_ROW   = 7'b0000100,
        ST_RD    = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_WR    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
        return (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
    endfunction

endpackage

@@ hdl/rgb565_raster_op_engine.sv @@
// Channel | Signals                                   | Handshake
// config  | cfg_we, cfg_index, cfg_data               | write when cfg_we high
// request | req_type..raster_op                       | start & !busy
// result  | status, pixel_value, rgb_value            | done strobe, one cycle
// A request with no pixel access goes through setup, a row check and done. Each
// pixel takes a read, a wait for the single-port store and a write; each row
// adds a row step before its pixels.
// Reset clears control and registers only; the pixel store keeps contents.
// The receiver cannot stall: done is high for one cycle per transaction.
module rgb565_raster_op_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] span_x,
    input  logic signed [15:0] span_y,
    input  logic signed [15:0] src_x,
    input  logic signed [15:0] src_y,
    input  logic [15:0] color,
    input  logic [3:0]  raster_op,
    output logic        done,
    output logic        status,
    output logic [15:0] pixel_value,
    output logic [31:0] rgb_value
);
    localparam int AW = rgb_rop_pkg::AddrW;
    localparam int CW = rgb_rop_pkg::CoordW;
    localparam int DW = rgb_rop_pkg::DimW;

    logic [15:0] mem [rgb_rop_pkg::StoreWords];
    logic [15:0] rdata;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata <= mem[mem_addr];
    end

    logic [15:0] dst_base_reg, dst_key_reg, src_base_reg, src_key_reg;
    logic [DW-1:0] dst_width_reg, dst_height_reg, src_width_reg, src_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_base_reg <= '0; dst_width_reg <= '0; dst_height_reg <= '0;
            dst_key_reg <= '0; src_base_reg <= '0; src_width_reg <= '0;
            src_height_reg <= '0; src_key_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgb_rop_pkg::RegDstBase:   dst_base_reg <= cfg_data;
                rgb_rop_pkg::RegDstWidth:  dst_width_reg <= cfg_data[DW-1:0];
                rgb_rop_pkg::RegDstHeight: dst_height_reg <= cfg_data[DW-1:0];
                rgb_rop_pkg::RegDstKey:    dst_key_reg <= cfg_data;
                rgb_rop_pkg::RegSrcBase:   src_base_reg <= cfg_data;
                rgb_rop_pkg::RegSrcWidth:  src_width_reg <= cfg_data[DW-1:0];
                rgb_rop_pkg::RegSrcHeight: src_height_reg <= cfg_data[DW-1:0];
                rgb_rop_pkg::RegSrcKey:    src_key_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DW-1:0] dw, dh, sw, sh;
    assign dw = rgb_rop_pkg::clamp_dim(dst_width_reg);
    assign dh = rgb_rop_pkg::clamp_dim(dst_height_reg);
    assign sw = rgb_rop_pkg::clamp_dim(src_width_reg);
    assign sh = rgb_rop_pkg::clamp_dim(src_height_reg);

    rgb_rop_pkg::state_t state_reg, state_next;

    logic [2:0]  req_reg;
    logic signed [CW-1:0] px_reg, py_reg, ex_reg, ey_reg, qx_reg, qy_reg;
    logic [15:0] color_reg;
    logic [3:0]  rop_reg;
    // loop bounds in offset space
    logic signed [CW-1:0] ilo_reg, ihi_reg, jhi_reg, i_reg, j_reg;
    logic [AW-1:0] daddr_reg, saddr_reg;
    logic [15:0] st_reg, pix_reg;
    logic [31:0] rgb_reg;
    logic        done_reg;

    logic signed [CW-1:0] dwx, dhx, swx, shx;
    assign dwx = CW'(dw);
    assign dhx = CW'(dh);
    assign swx = CW'(sw);
    assign shx = CW'(sh);

    logic d_ok, s_ok;
    assign d_ok = (dw != '0) && (dh != '0);
    assign s_ok = (sw != '0) && (sh != '0);

    function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction
    function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic signed [CW-1:0] jlo_c, jhi_c, ilo_c, ihi_c, lo_s, hi_s;
    logic [AW-1:0] dmul, smul;
    logic [AW-1:0] drow_c, srow_c;

    always_comb
    begin
        lo_s = smin(px_reg, ex_reg);
        hi_s = smax(px_reg, ex_reg);
        jlo_c = '0; jhi_c = '0; ilo_c = '0; ihi_c = '0;
        unique case (req_reg) inside
            rgb_rop_pkg::ReqPixel, rgb_rop_pkg::ReqGet:
            begin
                jhi_c = (py_reg >= 0 && py_reg < dhx) ? CW'(1) : '0;
                ilo_c = '0;
                ihi_c = (px_reg >= 0 && px_reg < dwx) ? CW'(1) : '0;
            end
            rgb_rop_pkg::ReqSpan:
            begin
                jhi_c = (py_reg >= 0 && py_reg < dhx) ? CW'(1) : '0;
                ilo_c = smax(lo_s, '0) - px_reg;
                ihi_c = smin(hi_s, dwx - CW'(1)) + CW'(1) - px_reg;
            end
            rgb_rop_pkg::ReqFill:
            begin
                jlo_c = smax('0, -py_reg);
                jhi_c = smin(ey_reg, dhx - py_reg);
                ilo_c = smax('0, -px_reg);
                ihi_c = smin(ex_reg, dwx - px_reg);
            end
            rgb_rop_pkg::ReqBlit:
            begin
                jlo_c = smax(smax('0, -qy_reg), -py_reg);
                jhi_c = smin(smin(ey_reg, shx - qy_reg), dhx - py_reg);
                ilo_c = smax(smax('0, -qx_reg), -px_reg);
                ihi_c = smin(smin(ex_reg, swx - qx_reg), dwx - px_reg);
            end
            default: ;
        endcase
        dmul = AW'(py_reg + j_reg) * AW'(dw);
        smul = AW'(qy_reg + j_reg) * AW'(sw);
        drow_c = dst_base_reg + dmul;
        srow_c = src_base_reg + smul;
    end

    logic xor_op, trans_op, is_blit;
    assign xor_op = (rop_reg == rgb_rop_pkg::RopXor);
    assign trans_op = (rop_reg == rgb_rop_pkg::RopTransparent);
    assign is_blit = (req_reg == rgb_rop_pkg::ReqBlit);

    always_comb
    begin
        mem_we = 1'b0;
        mem_wdata = color_reg;
        mem_addr = daddr_reg;
        state_next = state_reg;
        unique case (state_reg)
            rgb_rop_pkg::ST_IDLE:  if (start) state_next = rgb_rop_pkg::ST_SETUP;
            rgb_rop_pkg::ST_SETUP: state_next = rgb_rop_pkg::ST_ROW;
            rgb_rop_pkg::ST_ROW:
                state_next = (j_reg < jhi_reg && ilo_reg < ihi_reg)
                           ? rgb_rop_pkg::ST_RD : rgb_rop_pkg::ST_DONE;
            rgb_rop_pkg::ST_RD:
            begin
                mem_addr = is_blit ? saddr_reg : daddr_reg;
                state_next = rgb_rop_pkg::ST_WAIT;
            end
            rgb_rop_pkg::ST_WAIT:  state_next = rgb_rop_pkg::ST_WR;
            rgb_rop_pkg::ST_WR:
            begin
                if (is_blit)
                begin
                    mem_wdata = st_reg;
                    mem_we = !(trans_op && st_reg == src_key_reg);
                end
                else if (req_reg != rgb_rop_pkg::ReqGet)
                begin
                    mem_wdata = xor_op ? (st_reg ^ color_reg) : color_reg;
                    mem_we = 1'b1;
                end
                state_next = (i_reg + CW'(1) < ihi_reg) ? rgb_rop_pkg::ST_RD
                                                        : rgb_rop_pkg::ST_ROW;
            end
            rgb_rop_pkg::ST_DONE:  state_next = rgb_rop_pkg::ST_IDLE;
            default: state_next = rgb_rop_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rgb_rop_pkg::ST_WAIT)
            st_reg <= rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgb_rop_pkg::ST_IDLE;
            done_reg <= 1'b0;
            status <= 1'b0;
            pix_reg <= '0;
            rgb_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == rgb_rop_pkg::ST_DONE);
            unique case (state_reg)
                rgb_rop_pkg::ST_IDLE:
                    if (start)
                    begin
                        req_reg <= req_type;
                        px_reg <= CW'(pos_x); py_reg <= CW'(pos_y);
                        ex_reg <= CW'(span_x); ey_reg <= CW'(span_y);
                        qx_reg <= CW'(src_x); qy_reg <= CW'(src_y);
                        color_reg <= color; rop_reg <= raster_op;
                        pix_reg <= '0; rgb_reg <= '0; status <= 1'b0;
                    end
                rgb_rop_pkg::ST_SETUP:
                begin
                    ilo_reg <= ilo_c; ihi_reg <= ihi_c;
                    j_reg <= jlo_c; jhi_reg <= jhi_c;
                    if (req_reg == rgb_rop_pkg::ReqRgb)
                        rgb_reg <= {color_reg[4:0], 3'd0, color_reg[10:5], 2'd0,
                                    color_reg[15:11], 11'd0};
                    if (req_reg > rgb_rop_pkg::ReqBlit ||
                        (is_blit && (!d_ok || !s_ok)) || (!is_blit && !d_ok) ||
                        (req_reg == rgb_rop_pkg::ReqFill && trans_op &&
                         color_reg == dst_key_reg))
                    begin
                        status <= (req_reg <= rgb_rop_pkg::ReqBlit) &&
                                  (!d_ok || (is_blit && !s_ok));
                        jhi_reg <= '0; j_reg <= '0;
                    end
                end
                rgb_rop_pkg::ST_ROW:
                begin
                    i_reg <= ilo_reg;
                    daddr_reg <= drow_c + AW'(px_reg + ilo_reg);
                    saddr_reg <= srow_c + AW'(qx_reg + ilo_reg);
                end
                rgb_rop_pkg::ST_WR:
                begin
                    if (req_reg == rgb_rop_pkg::ReqGet)
                        pix_reg <= st_reg;
                    i_reg <= i_reg + CW'(1);
                    daddr_reg <= daddr_reg + AW'(1);
                    saddr_reg <= saddr_reg + AW'(1);
                    if (i_reg + CW'(1) >= ihi_reg)
                        j_reg <= j_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != rgb_rop_pkg::ST_IDLE);
    assign done = done_reg;
    assign pixel_value = pix_reg;
    assign rgb_value = rgb_reg;

endmodule

@@ hdl/rgb_rop_checker.sv @@
module rgb_rop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] pixel_value,
    input logic [31:0] rgb_value
);
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while still busy");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        done && pixel_value != 16'd0 |-> rgb_value == 32'd0)
        else $error("both pixel and rgb results set");
endmodule

bind rgb565_raster_op_engine rgb_rop_checker u_rgb_rop_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .pixel_value(pixel_value), .rgb_value(rgb_value)
);
